// ----- rtl/core/brace_assign_lexer_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the brace/assignment lexer
// Shared property shapes used by the lexer's checker.
// ---------------------------------------------------------------------------
`ifndef BRACE_ASSIGN_LEXER_ASSERT_SVH
`define BRACE_ASSIGN_LEXER_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define BAL_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lexer assertion failed");

// Next-cycle implication, ignored while reset is high.
`define BAL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lexer assertion failed");

// Next-cycle implication that is also checked across reset.
`define BAL_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("lexer assertion failed");

`endif

// ----- rtl/core/bal_pkg.sv -----
// ---------------------------------------------------------------------------
// Lexer package
// Widths, character codes and result kinds shared by the lexer files.
// ---------------------------------------------------------------------------
package bal_pkg;

   // Width of the internal saturating line counter.
   localparam int LineBits    = 16;
   // Width of the line number carried on a result.
   localparam int OutLineBits = 16;
   // Most results one character can cause.
   localparam int MaxResults  = 3;

   // Character codes.
   localparam logic [7:0] ChrCr      = 8'd13;
   localparam logic [7:0] ChrNl      = 8'd10;
   localparam logic [7:0] ChrSpace   = 8'h20;
   localparam logic [7:0] ChrLbrace  = 8'h7B;
   localparam logic [7:0] ChrRbrace  = 8'h7D;
   localparam logic [7:0] ChrEquals  = 8'h3D;
   localparam logic [7:0] ChrSemi    = 8'h3B;
   localparam logic [7:0] ChrZero    = 8'h30;
   localparam logic [7:0] ChrNine    = 8'h39;
   localparam logic [7:0] ChrLowA    = 8'h61;
   localparam logic [7:0] ChrLowZ    = 8'h7A;
   localparam logic [7:0] ChrUpA     = 8'h41;
   localparam logic [7:0] ChrUpZ     = 8'h5A;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_CHAR = 2'd0,
      KIND_END  = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   // Results caused by one character, in order, with their shared line.
   typedef struct packed {
      logic [1:0]                     count;
      kind_type [MaxResults-1:0]      kind;
      logic [MaxResults-1:0][7:0]     value;
      logic [LineBits-1:0]            line;
   } bundle_type;

endpackage

// ----- rtl/core/bal_if.sv -----
// ---------------------------------------------------------------------------
// Lexer channel interfaces
// Valid/ready channels for input characters and lexer results.
// ---------------------------------------------------------------------------
interface bal_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       start_text;

   modport source (output valid, output char_code, output start_text, input ready);
   modport sink   (input valid, input char_code, input start_text, output ready);
endinterface

interface bal_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  value;
   logic [15:0] line_number;
   logic        last;

   modport source (output valid, output kind, output value, output line_number,
                   output last, input ready);
   modport sink   (input valid, input kind, input value, input line_number,
                   input last, output ready);
endinterface

// ----- rtl/core/bal_lex.sv -----
// ---------------------------------------------------------------------------
// Lexer state and step logic
// Holds the lexer mode and line counter and works out the results of one
// character from them.
// ---------------------------------------------------------------------------
module bal_lex (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         char_code,
   input  logic               start_text,
   output bal_pkg::bundle_type bundle
);
   import bal_pkg::*;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_NAME   = 2'd1,
      MODE_NUMBER = 2'd2,
      MODE_HALT   = 2'd3
   } mode_type;

   localparam logic [LineBits-1:0] LineOne = LineBits'(1);
   localparam logic [LineBits-1:0] LineMax = {LineBits{1'b1}};

   mode_type            mode_ff, mode_in, mode_cur;
   logic [LineBits-1:0] line_ff, line_in, line_cur, line_bump;
   logic                is_digit, is_letter, is_single;

   // A start flag discards the open token before the character is lexed.
   assign mode_cur  = start_text ? MODE_IDLE : mode_ff;
   assign line_cur  = start_text ? LineOne : line_ff;
   assign line_bump = (line_cur == LineMax) ? line_cur : line_cur + LineOne;

   // Character classes.
   assign is_digit  = (char_code >= ChrZero) && (char_code <= ChrNine);
   assign is_letter = ((char_code >= ChrLowA) && (char_code <= ChrLowZ)) ||
                      ((char_code >= ChrUpA)  && (char_code <= ChrUpZ));
   assign is_single = (char_code == ChrLbrace) || (char_code == ChrRbrace) ||
                      (char_code == ChrEquals) || (char_code == ChrSemi);

   // Next mode, next line and the results of this character.
   always_comb begin
      mode_in      = mode_cur;
      line_in      = line_cur;
      bundle.count = 2'd0;
      bundle.kind  = {MaxResults{KIND_END}};
      bundle.value = '0;
      unique case (mode_cur)
         MODE_IDLE: begin
            if (char_code == ChrSpace) begin
               mode_in = MODE_IDLE;
            end else if ((char_code == ChrCr) || (char_code == ChrNl)) begin
               line_in = line_bump;
            end else if (is_single) begin
               bundle.count    = 2'd2;
               bundle.kind[0]  = KIND_CHAR;
               bundle.value[0] = char_code;
            end else if (is_digit) begin
               bundle.count    = 2'd1;
               bundle.kind[0]  = KIND_CHAR;
               bundle.value[0] = char_code;
               mode_in         = MODE_NUMBER;
            end else if (is_letter) begin
               bundle.count    = 2'd1;
               bundle.kind[0]  = KIND_CHAR;
               bundle.value[0] = char_code;
               mode_in         = MODE_NAME;
            end else begin
               bundle.count    = 2'd1;
               bundle.kind[0]  = KIND_ERR;
               bundle.value[0] = char_code;
               mode_in         = MODE_HALT;
            end
         end
         MODE_NAME, MODE_NUMBER: begin
            if ((char_code == ChrNl) || (char_code == ChrSpace)) begin
               // A newline advances the line before the token closes.
               if (char_code == ChrNl) begin
                  line_in = line_bump;
               end
               bundle.count = 2'd1;
               mode_in      = MODE_IDLE;
            end else if (is_single) begin
               bundle.count    = 2'd3;
               bundle.kind[1]  = KIND_CHAR;
               bundle.value[1] = char_code;
               mode_in         = MODE_IDLE;
            end else if (is_digit || ((mode_cur == MODE_NAME) && is_letter)) begin
               bundle.count    = 2'd1;
               bundle.kind[0]  = KIND_CHAR;
               bundle.value[0] = char_code;
            end else begin
               bundle.count    = 2'd1;
               bundle.kind[0]  = KIND_ERR;
               bundle.value[0] = char_code;
               mode_in         = MODE_HALT;
            end
         end
         MODE_HALT: begin
            mode_in = MODE_HALT;
         end
         default: begin
            mode_in = MODE_HALT;
         end
      endcase
      // Every result of a character shows the line left after it.
      bundle.line = line_in;
   end

   // Mode and line counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         line_ff <= LineOne;
      end else if (step) begin
         mode_ff <= mode_in;
         line_ff <= line_in;
      end
   end

endmodule

// ----- rtl/core/brace_assign_lexer.sv -----
// ---------------------------------------------------------------------------
// Brace/assignment lexer
// Lexes one text character per transaction into token characters, token
// ends and syntax errors, each tagged with the current line number.
// ---------------------------------------------------------------------------
//  Channel   Direction  Transaction
//  req_if    in         one text character and its start-of-text flag
//  rsp_if    out        one result: kind, value, line number, last flag
//
//  A character is lexed from an input register into a result register; its
//  up to three results leave one per cycle while the receiver is ready.
//  Sustained rate is one character per cycle while the receiver is ready
//  and each causes at most one result; the result register sets the pace.
//  Reset is synchronous and brings the lexer to idle mode on line one.
//  A stalled result holds one character in the input register behind it.
// ---------------------------------------------------------------------------
module brace_assign_lexer (
   input  logic      clock,
   input  logic      reset,
   bal_req_if.sink   req_if,
   bal_rsp_if.source rsp_if
);
   import bal_pkg::*;

   // Input register.
   logic       in_valid_ff;
   logic [7:0] char_ff;
   logic       start_ff;

   // Result register: the results of one character and a read position.
   bundle_type bun_ff;
   bundle_type lex_bundle;
   logic [1:0] left_ff, left_in;
   logic [1:0] pos_ff, pos_in;

   logic take, bundle_free, advance;

   assign take        = rsp_if.valid && rsp_if.ready;
   assign bundle_free = (left_ff == 2'd0) || ((left_ff == 2'd1) && rsp_if.ready);
   assign advance     = in_valid_ff && bundle_free;
   assign req_if.ready = !in_valid_ff || advance;

   bal_lex u_lex (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .char_code  (char_ff),
      .start_text (start_ff),
      .bundle     (lex_bundle)
   );

   // Input register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         char_ff  <= req_if.char_code;
         start_ff <= req_if.start_text;
      end
   end

   // Result register: load a new bundle or step through the current one.
   always_comb begin
      left_in = left_ff;
      pos_in  = pos_ff;
      if (advance) begin
         left_in = lex_bundle.count;
         pos_in  = 2'd0;
      end else if (take) begin
         left_in = left_ff - 2'd1;
         pos_in  = pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= 2'd0;
         pos_ff  <= 2'd0;
      end else begin
         left_ff <= left_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         bun_ff <= lex_bundle;
      end
   end

   // Result transaction.
   assign rsp_if.valid = (left_ff != 2'd0);
   assign rsp_if.kind  = bun_ff.kind[pos_ff];
   assign rsp_if.value = bun_ff.value[pos_ff];
   assign rsp_if.last  = (left_ff == 2'd1);

   generate
      if (LineBits >= OutLineBits) begin : g_line_trunc
         assign rsp_if.line_number = bun_ff.line[OutLineBits-1:0];
      end else begin : g_line_ext
         assign rsp_if.line_number = {{(OutLineBits-LineBits){1'b0}}, bun_ff.line};
      end
   endgenerate

endmodule

// ----- rtl/core/bal_checker.sv -----
// ---------------------------------------------------------------------------
// Lexer port checker
// Watches the lexer's result channel for rule breaks over time.
// ---------------------------------------------------------------------------
`include "brace_assign_lexer_assert.svh"

module bal_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [7:0]  rsp_value,
   input logic [15:0] rsp_line_number,
   input logic        rsp_last
);
   import bal_pkg::*;

   // An error halts the lexer, so it is always the final result of its character.
   `BAL_ASSERT_NOW(a_err_is_last, clock, reset, rsp_valid && (rsp_kind == KIND_ERR), rsp_last)

   // A token end carries no character.
   `BAL_ASSERT_NOW(a_end_value_zero, clock, reset, rsp_valid && (rsp_kind == KIND_END), rsp_value == 8'd0)

   // Nothing is offered right after reset.
   `BAL_ASSERT_NEXT_ALWAYS(a_reset_quiet, clock, reset, !rsp_valid)

   // A stalled result holds.
   `BAL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_value) && $stable(rsp_line_number) && $stable(rsp_last))

endmodule

bind brace_assign_lexer bal_checker u_bal_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_kind        (rsp_if.kind),
   .rsp_value       (rsp_if.value),
   .rsp_line_number (rsp_if.line_number),
   .rsp_last        (rsp_if.last)
);
